@@ hdl/swg_pkg.sv @@
package swg_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC       = 12;
	localparam int DEPTH_LOG2 = 8;
	localparam int DEPTH      = 1 << DEPTH_LOG2;
	localparam int SIG_W      = FRAC + 1;
	localparam int Z_W        = 2 * DATA_W;
	localparam int IDX_W      = DEPTH_LOG2 + 1;
	// position of the table index and the blend weight inside (z + 8)
	localparam int IDX_SHIFT  = 2 * FRAC + 4 - DEPTH_LOG2;
	localparam int W_SHIFT    = FRAC + 4 - DEPTH_LOG2;

	localparam logic signed [Z_W-1:0] EIGHT = Z_W'(64'sd8 <<< (2 * FRAC));
	localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << FRAC;
	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] ALPHA_RESET =
		(FRAC >= DATA_W - 1) ? DATA_MAX : DATA_W'(64'sd1 <<< FRAC);

	localparam longint unsigned Q31_ONE  = 64'd1 << 31;
	localparam longint unsigned Q31_EINV = 64'd790015084;

	typedef struct packed {
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} swg_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gated_value;
		logic                     saturated;
	} swg_out_t;

	// sigmoid result handed from the table unit to the product unit
	typedef struct packed {
		logic                     valid;
		logic [SIG_W-1:0]         sig;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} swg_gate_t;

	typedef logic [SIG_W-1:0] sig_tab_t [0:DEPTH];

	// shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned const_udiv(longint unsigned num,
			longint unsigned dvs);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= dvs) begin
				r = r - dvs;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid(-8 + 16*i/DEPTH), unsigned Q.FRAC, built at elaboration
	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		longint unsigned a16, mid, mag, t, n, f, e, term, num, den, k;
		longint sum;
		bit neg;
		for (int i = 0; i <= DEPTH; i++) begin
			a16 = 64'd16 * longint'(i);
			mid = 64'd8 * longint'(DEPTH);
			neg = a16 < mid;
			mag = neg ? mid - a16 : a16 - mid;
			t = (mag << 31) >> DEPTH_LOG2;
			n = t >> 31;
			f = t & (Q31_ONE - 1);
			e = Q31_ONE;
			term = Q31_ONE;
			sum = longint'(Q31_ONE);
			for (k = 0; k < n; k++)
				e = (e * Q31_EINV + (Q31_ONE >> 1)) >> 31;
			for (k = 1; k <= 16; k++) begin
				term = const_udiv((term * f) >> 31, k);
				if (k[0])
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			e = (e * longint'(sum)) >> 31;
			num = neg ? e : Q31_ONE;
			den = Q31_ONE + e;
			tab[i] = SIG_W'(const_udiv((num << FRAC) + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ hdl/swg_sigmoid.sv @@
module swg_sigmoid import swg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  swg_in_t                  operands,
	input  logic signed [DATA_W-1:0] alpha,
	output swg_gate_t                gate
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [Z_W-1:0]    z_s1;
	swg_in_t                  op_s1, op_s2, op_s3;
	logic                     lo_s2, hi_s2;
	logic [SIG_W-1:0]         t0_s2, t1_s2;
	logic [FRAC-1:0]          w_s2;
	logic [SIG_W-1:0]         sig_s3;

	logic [Z_W-1:0]           u;
	logic [DEPTH_LOG2-1:0]    idx;
	logic [IDX_W-1:0]         idx_next;
	logic signed [SIG_W:0]    diff;
	logic signed [SIG_W+FRAC+2:0] blend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// table position of z + 8; only meaningful when z lies in [-8, 8)
	assign u        = Z_W'(z_s1 + EIGHT);
	assign idx      = u[IDX_SHIFT +: DEPTH_LOG2];
	assign idx_next = {1'b0, idx} + IDX_W'(1);

	// t0 + (t1 - t0) * w equals t0 * (1 - w) + t1 * w
	assign diff  = signed'({1'b0, t1_s2}) - signed'({1'b0, t0_s2});
	assign blend = (SIG_W+FRAC+3)'(signed'({1'b0, t0_s2, {FRAC{1'b0}}}))
		+ (SIG_W+FRAC+3)'(diff * signed'({1'b0, w_s2}))
		+ (SIG_W+FRAC+3)'(signed'({1'b0, 1'b1, {(FRAC-1){1'b0}}}));

	always_ff @(posedge clk) begin
		z_s1  <= Z_W'(alpha * operands.operand_a);
		op_s1 <= operands;

		lo_s2 <= z_s1 < -EIGHT;
		hi_s2 <= z_s1 >= EIGHT;
		t0_s2 <= SIG_TABLE[{1'b0, idx}];
		t1_s2 <= SIG_TABLE[idx_next];
		w_s2  <= u[W_SHIFT +: FRAC];
		op_s2 <= op_s1;

		priority if (lo_s2) begin
			sig_s3 <= '0;
		end else if (hi_s2) begin
			sig_s3 <= SIG_ONE;
		end else begin
			sig_s3 <= blend[FRAC +: SIG_W];
		end
		op_s3 <= op_s2;
	end

	assign gate.valid     = valid_s3;
	assign gate.sig       = sig_s3;
	assign gate.operand_a = op_s3.operand_a;
	assign gate.operand_b = op_s3.operand_b;

endmodule

@@ hdl/swg_product.sv @@
module swg_product import swg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  swg_gate_t gate,
	output logic      done,
	output swg_out_t  result
);

	localparam int P1_W   = DATA_W + 1;
	localparam int A_S_W  = DATA_W + SIG_W + 1;
	localparam int PROD_W = P1_W + DATA_W;
	localparam int RES_W  = PROD_W - FRAC;

	logic                     valid_s4, valid_s5, valid_s6;
	logic signed [P1_W-1:0]   p1_s4;
	logic signed [DATA_W-1:0] b_s4;
	logic signed [PROD_W-1:0] prod_s5;
	swg_out_t                 result_s6;

	logic signed [A_S_W-1:0]  a_s;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [RES_W-1:0]  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= gate.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// round to nearest, ties toward plus infinity, then drop the fraction
	assign a_s = A_S_W'(gate.operand_a * signed'({1'b0, gate.sig}))
		+ A_S_W'(signed'({1'b0, 1'b1, {(FRAC-1){1'b0}}}));
	assign prod_rnd = prod_s5 + PROD_W'(signed'({1'b0, 1'b1, {(FRAC-1){1'b0}}}));
	assign res      = prod_rnd[PROD_W-1:FRAC];

	always_ff @(posedge clk) begin
		p1_s4   <= a_s[FRAC +: P1_W];
		b_s4    <= gate.operand_b;
		prod_s5 <= PROD_W'(p1_s4 * b_s4);

		priority if (res > RES_W'(DATA_MAX)) begin
			result_s6.gated_value <= DATA_MAX;
			result_s6.saturated   <= 1'b1;
		end else if (res < RES_W'(DATA_MIN)) begin
			result_s6.gated_value <= DATA_MIN;
			result_s6.saturated   <= 1'b1;
		end else begin
			result_s6.gated_value <= res[DATA_W-1:0];
			result_s6.saturated   <= 1'b0;
		end
	end

	assign done   = valid_s6;
	assign result = result_s6;

endmodule

@@ hdl/swiglu_gate_top.sv @@
// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------
// request   | start in, busy out       | operands (operand_a, operand_b)
// result    | done out (one-cycle)     | result (gated_value, saturated)
// config    | cfg_valid in, cfg_ready  | cfg_data (gate_alpha)
//
// One request per cycle.
// The six stages are alpha*a, table lookup, blend, a*sigmoid, times b, and
// round with saturation; the multipliers in stages one, three, four and five
// set the clock.
// busy stays low and cfg_ready stays high: nothing inside ever blocks.
// Reset clears the stage valid bits and loads alpha with 1.0.
// The receiver cannot stall, so results are never held.
module swiglu_gate_top import swg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  swg_in_t                  operands,
	output logic                     done,
	output swg_out_t                 result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic signed [DATA_W-1:0] cfg_data
);

	logic signed [DATA_W-1:0] alpha_q;
	swg_gate_t                gate;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_q <= cfg_data;
		end
	end

	swg_sigmoid u_sigmoid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.operands (operands),
		.alpha    (alpha_q),
		.gate     (gate)
	);

	swg_product u_product (
		.clk    (clk),
		.arst_n (arst_n),
		.gate   (gate),
		.done   (done),
		.result (result)
	);

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	import swg_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam longint Z_EIGHT = 64'sd8 <<< (2 * FRAC);
	localparam longint SIG_UNITY = 64'sd1 <<< FRAC;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	swg_in_t operands;
	logic done;
	swg_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic signed [DATA_W-1:0] cfg_data;

	swiglu_gate_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operands  (operands),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// bench copy of the sigmoid curve and of the alpha register
	longint sigmoid_lut [0:DEPTH];
	logic signed [DATA_W-1:0] alpha_q;

	swg_in_t pending_requests [$];
	swg_out_t due_results [$];
	int n_queued;
	int n_accepted;
	int n_results;
	int n_errors;
	int idle_cycles;
	bit req_taken;
	bit burst_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sigmoid(-8 + 16*i/DEPTH) in unsigned Q.FRAC, via a Q31 exp(-|x|)
	initial begin : lut_fill
		longint unsigned span, mid, mag, t, whole, part, e, term, num, den;
		longint acc;
		bit below;
		for (int i = 0; i <= DEPTH; i++) begin
			span = 64'd16 * i;
			mid = 64'd8 * DEPTH;
			below = span < mid;
			mag = below ? mid - span : span - mid;
			t = (mag << 31) / DEPTH;
			whole = t >> 31;
			part = t & (Q31_ONE - 1);
			e = Q31_ONE;
			term = Q31_ONE;
			acc = Q31_ONE;
			for (longint unsigned k = 0; k < whole; k++)
				e = (e * Q31_EINV + (Q31_ONE >> 1)) >> 31;
			for (longint unsigned k = 1; k <= 16; k++) begin
				term = ((term * part) >> 31) / k;
				if (k[0])
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			e = (e * longint'(acc)) >> 31;
			num = below ? e : Q31_ONE;
			den = Q31_ONE + e;
			sigmoid_lut[i] = longint'(((num << FRAC) + (den >> 1)) / den);
		end
	end

	function automatic swg_out_t gate_predict(logic signed [DATA_W-1:0] alpha,
			swg_in_t req);
		longint a, b, z, sig, w, p1, res;
		longint unsigned pos, idx;
		swg_out_t r;
		a = req.operand_a;
		b = req.operand_b;
		z = longint'(alpha) * a;
		if (z < -Z_EIGHT) begin
			sig = 0;
		end else if (z >= Z_EIGHT) begin
			sig = SIG_UNITY;
		end else begin
			pos = longint'(z + Z_EIGHT) * DEPTH;
			idx = pos >> (2 * FRAC + 4);
			if (idx >= DEPTH)
				idx = DEPTH - 1;
			w = longint'((pos >> (FRAC + 4)) & (SIG_UNITY - 1));
			sig = (sigmoid_lut[idx] * (SIG_UNITY - w) + sigmoid_lut[idx + 1] * w
				+ (SIG_UNITY >>> 1)) >>> FRAC;
		end
		// round half up at both products
		p1 = (a * sig + (SIG_UNITY >>> 1)) >>> FRAC;
		res = (p1 * b + (SIG_UNITY >>> 1)) >>> FRAC;
		r.saturated = 1'b0;
		if (res > longint'(DATA_MAX)) begin
			res = DATA_MAX;
			r.saturated = 1'b1;
		end else if (res < longint'(DATA_MIN)) begin
			res = DATA_MIN;
			r.saturated = 1'b1;
		end
		r.gated_value = res[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_operand();
		int k;
		case ($urandom_range(0, 3))
			0: return DATA_W'($urandom);
			1: return DATA_W'($urandom_range(0, 16383) - 8192);
			2: begin
				case ($urandom_range(0, 4))
					0: return DATA_MIN;
					1: return DATA_MAX;
					2: return '0;
					3: return '1;
					default: return DATA_W'(1);
				endcase
			end
			default: begin
				k = $urandom_range(0, DATA_W - 2);
				return DATA_W'($urandom_range(0, 1) ? -(1 << k) : (1 << k));
			end
		endcase
	endfunction

	task automatic queue_request(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
		swg_in_t req;
		req.operand_a = a;
		req.operand_b = b;
		pending_requests.push_back(req);
		n_queued++;
	endtask

	task automatic wait_drained();
		wait (n_accepted == n_queued && n_results == n_accepted);
	endtask

	task automatic write_alpha(logic signed [DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// request driver: hold a request until taken, then advance or idle
	always @(negedge clk) begin : request_drive
		swg_in_t nxt;
		bit go;
		if (arst_n && (!start || req_taken)) begin
			go = pending_requests.size() != 0
				&& (burst_mode || $urandom_range(0, 99) >= 20);
			if (go) begin
				nxt = pending_requests.pop_front();
				start <= 1'b1;
				operands <= nxt;
			end else begin
				start <= 1'b0;
				operands <= $urandom;
			end
		end
	end

	always @(posedge clk) begin : result_check
		swg_out_t want;
		bit moved;
		if (arst_n) begin
			req_taken = start && !busy;
			moved = req_taken;
			if (done !== 1'b0) begin
				if (due_results.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result gated_value=%0d saturated=%b",
						$realtime, result.gated_value, result.saturated);
				end else begin
					moved = 1'b1;
					want = due_results.pop_front();
					n_results++;
					if (result.gated_value !== want.gated_value) begin
						n_errors++;
						$display("%0t: gated_value expected %0d actual %0d",
							$realtime, want.gated_value, result.gated_value);
					end
					if (result.saturated !== want.saturated) begin
						n_errors++;
						$display("%0t: saturated expected %b actual %b",
							$realtime, want.saturated, result.saturated);
					end
				end
			end
			if (req_taken) begin
				due_results.push_back(gate_predict(alpha_q, operands));
				n_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				alpha_q = cfg_data;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int alpha_plan [10];
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		alpha_q = ALPHA_RESET;
		n_queued = 0;
		n_accepted = 0;
		n_results = 0;
		n_errors = 0;
		idle_cycles = 0;
		req_taken = 1'b0;
		burst_mode = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// alpha at its reset value of 1.0: extremes, tiny values, saturation
		queue_request(0, 0);
		queue_request(DATA_MAX, DATA_MAX);
		queue_request(DATA_MIN, DATA_MIN);
		queue_request(DATA_MAX, DATA_MIN);
		queue_request(DATA_MIN, DATA_MAX);
		queue_request(4096, 4096);
		queue_request(-4096, 4096);
		queue_request(1, 1);
		queue_request(-1, -1);
		queue_request(DATA_MAX, 1);
		queue_request(DATA_MIN, -1);
		queue_request(16384, -4096);
		queue_request(-16384, 4096);
		queue_request(2048, DATA_MAX);
		queue_request(DATA_MIN, 0);
		queue_request(0, DATA_MIN);
		queue_request(8191, 8191);
		queue_request(-20000, 12345);
		queue_request(DATA_MAX, 4096);
		queue_request(-1, DATA_MIN);
		repeat (150) queue_request(rand_operand(), rand_operand());
		wait_drained();

		// sweep alpha through its extremes and back to 1.0
		alpha_plan = '{32767, -32768, 0, 1, -1, -4096, 8192, 2048, 0, 4096};
		alpha_plan[8] = $urandom_range(0, 65535) - 32768;
		foreach (alpha_plan[i]) begin
			write_alpha(DATA_W'(alpha_plan[i]));
			burst_mode = (i == 6);
			if (i == 0) begin
				queue_request(DATA_MAX, DATA_MAX);
				queue_request(DATA_MIN, DATA_MAX);
				queue_request(1, 4096);
				queue_request(-1, 4096);
			end
			repeat (burst_mode ? 100 : 50) queue_request(rand_operand(), rand_operand());
			wait_drained();
		end
		burst_mode = 1'b0;

		repeat (12) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
